@@ rtl/c8080_pkg.sv @@
// shared constants and types for the 8080 instruction step core
`timescale 1ns / 1ps

package c8080_pkg;

	// memory address width; addresses keep their low ADDR_BITS bits
	localparam int unsigned ADDR_BITS = 16;
	localparam int unsigned MEM_DEPTH = 2 ** ADDR_BITS;

	// accumulator operations, selected by opcode bits 5:3
	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBB = 3'd3;
	localparam logic [2:0] ALU_ANA = 3'd4;
	localparam logic [2:0] ALU_XRA = 3'd5;
	localparam logic [2:0] ALU_ORA = 3'd6;
	localparam logic [2:0] ALU_CMP = 3'd7;

	// accumulator unit result: value, flags and accumulator write enable
	typedef struct packed {
		logic [7:0] r;
		logic       s;
		logic       z;
		logic       ac;
		logic       p;
		logic       c;
		logic       wr_a;
	} alu_res_t;

endpackage

@@ rtl/c8080_ram.sv @@
// generic single port ram with registered read
`timescale 1ns / 1ps

module c8080_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// a write when we is high, and a registered read of the same address, each cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/c8080_alu.sv @@
// shared 8-bit accumulator unit: add, subtract, compare and logic ops
`timescale 1ns / 1ps

module c8080_alu import c8080_pkg::*; (
	input  logic [2:0] op,
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  logic       cy,
	output alu_res_t   res
);

	logic       is_sub;
	logic [7:0] bb;
	logic       cin;
	logic [8:0] sum;
	logic [4:0] half;

	// one adder serves add and subtract forms
	assign is_sub = (op == ALU_SUB) || (op == ALU_SBB) || (op == ALU_CMP);
	assign bb     = is_sub ? ~b : b;
	always_comb begin
		case (op)
			ALU_ADC: cin = cy;
			ALU_SUB: cin = 1'b1;
			ALU_SBB: cin = ~cy;
			ALU_CMP: cin = 1'b1;
			default: cin = 1'b0;
		endcase
	end
	assign sum  = {1'b0, a} + {1'b0, bb} + {8'd0, cin};
	assign half = {1'b0, a[3:0]} + {1'b0, bb[3:0]} + {4'd0, cin};

	// result select and flags
	always_comb begin
		res.wr_a = (op != ALU_CMP);
		case (op)
			ALU_ADD, ALU_ADC: begin
				res.r  = sum[7:0];
				res.ac = half[4];
				res.c  = sum[8];
			end
			ALU_SUB, ALU_SBB, ALU_CMP: begin
				res.r  = sum[7:0];
				res.ac = half[4];
				res.c  = ~sum[8];
			end
			ALU_ANA: begin
				res.r  = a & b;
				res.ac = a[3] | b[3];
				res.c  = 1'b0;
			end
			ALU_XRA: begin
				res.r  = a ^ b;
				res.ac = 1'b0;
				res.c  = 1'b0;
			end
			default: begin
				res.r  = a | b;
				res.ac = 1'b0;
				res.c  = 1'b0;
			end
		endcase
		res.s = res.r[7];
		res.z = (res.r == 8'd0);
		res.p = ~^res.r;
	end

endmodule

@@ rtl/cpu8080_instruction_step.sv @@
// 8080 core stepped one command word at a time, with a flat byte memory
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_ready  | command, address, data
//  out     | out_valid/out_ready| program_counter .. bad_opcode (one per command)
//
//  an execute fetches the opcode and its immediates, reads its memory operands,
//  executes, then writes back any memory bytes; a read or write command is one access.
//  all accesses share the single memory port, one access a cycle with registered read.
//  reset clears the state, cpu registers, flags and halt; memory is undefined until written.
//  in_ready is high only in idle; a finished word waits in the output register
//  while the next command is taken, and the core stalls before its own result if
//  the previous word is still not taken.
`timescale 1ns / 1ps

module cpu8080_instruction_step import c8080_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] program_counter,
	output logic [15:0] stack_pointer,
	output logic [7:0]  accumulator,
	output logic [7:0]  status_flags,
	output logic        halted,
	output logic        port_write_valid,
	output logic [7:0]  port_number,
	output logic [7:0]  port_data,
	output logic [7:0]  read_data,
	output logic        bad_opcode
);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_EXEC  = 2'd2;

	localparam logic [1:0] BASE_HL  = 2'd0;
	localparam logic [1:0] BASE_RP  = 2'd1;
	localparam logic [1:0] BASE_IMM = 2'd2;
	localparam logic [1:0] BASE_SP  = 2'd3;

	localparam logic [7:0] OP_HLT = 8'h76;
	localparam logic [7:0] OP_BAD = 8'hCB;

	typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_RDW, ST_EXEC, ST_WR, ST_DONE} state_t;
	typedef enum logic [1:0] {PH_OP, PH_IMM, PH_MEM, PH_CMD} phase_t;

	// byte counts and operand address source of one opcode
	typedef struct packed {
		logic [1:0] n_imm;
		logic [1:0] n_mem;
		logic [1:0] base;
	} dec_t;

	state_t      state_q;
	phase_t      phase_q;
	logic        cnt_q;
	logic [1:0]  cmd_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q;
	logic [7:0]  op_q;
	logic [15:0] imm_q;
	logic [15:0] mem_q;

	logic [15:0] pc_q, sp_q, bc_q, de_q, hl_q;
	logic [7:0]  a_q;
	logic [4:0]  fl_q;   // S Z AC P C
	logic        halt_q;

	logic [1:0]  wr_n_q;
	logic [15:0] wr_base_q;
	logic [15:0] wr_data_q;
	logic        pw_q, bad_q;
	logic [7:0]  pn_q, pd_q, rdat_q;

	logic        out_valid_q;
	logic [15:0] o_pc_q, o_sp_q;
	logic [7:0]  o_a_q, o_fl_q, o_pn_q, o_pd_q, o_rdat_q;
	logic        o_halt_q, o_pw_q, o_bad_q;

	logic        acc;
	logic [7:0]  ram_rdata;
	logic [7:0]  ram_wdata;
	logic [15:0] ram_addr16;
	logic        ram_we;

	logic [7:0]  op_now;
	logic        cond_now;
	dec_t        dec;
	logic [15:0] base_addr;
	logic [15:0] rd_addr;

	// ---------------------------------------------------------------- helpers

	function automatic logic [7:0] reg8(input logic [2:0] id, input logic [15:0] bc,
			input logic [15:0] de, input logic [15:0] hl, input logic [7:0] m,
			input logic [7:0] a);
		logic [7:0] r;
		case (id)
			3'd0:    r = bc[15:8];
			3'd1:    r = bc[7:0];
			3'd2:    r = de[15:8];
			3'd3:    r = de[7:0];
			3'd4:    r = hl[15:8];
			3'd5:    r = hl[7:0];
			3'd6:    r = m;
			default: r = a;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] pair16(input logic [1:0] rp, input logic [15:0] bc,
			input logic [15:0] de, input logic [15:0] hl, input logic [15:0] sp);
		logic [15:0] r;
		case (rp)
			2'd0:    r = bc;
			2'd1:    r = de;
			2'd2:    r = hl;
			default: r = sp;
		endcase
		return r;
	endfunction

	function automatic logic cond_ok(input logic [2:0] cc, input logic [4:0] fl);
		logic f;
		case (cc[2:1])
			2'd0:    f = fl[3];
			2'd1:    f = fl[0];
			2'd2:    f = fl[1];
			default: f = fl[4];
		endcase
		return cc[0] ? f : ~f;
	endfunction

	function automatic logic [2:0] szp(input logic [7:0] v);
		return {v[7], v == 8'd0, ~^v};
	endfunction

	function automatic dec_t decode(input logic [7:0] op, input logic cnd);
		dec_t       d;
		logic [2:0] dst;
		logic [2:0] src;
		d   = '0;
		dst = op[5:3];
		src = op[2:0];
		case (op[7:6])
			2'd1, 2'd2: begin
				if (src == 3'd6 && op != OP_HLT) begin
					d.n_mem = 2'd1;
					d.base  = BASE_HL;
				end
			end
			2'd0: begin
				case (src)
					3'd1: if (!dst[0]) d.n_imm = 2'd2;
					3'd2: begin
						if (dst[2]) d.n_imm = 2'd2;
						if (dst == 3'd7) begin
							d.n_mem = 2'd1;
							d.base  = BASE_IMM;
						end else if (dst == 3'd5) begin
							d.n_mem = 2'd2;
							d.base  = BASE_IMM;
						end else if (!dst[2] && dst[0]) begin
							d.n_mem = 2'd1;
							d.base  = BASE_RP;
						end
					end
					3'd4, 3'd5: begin
						if (dst == 3'd6) begin
							d.n_mem = 2'd1;
							d.base  = BASE_HL;
						end
					end
					3'd6: d.n_imm = 2'd1;
					default: ;
				endcase
			end
			default: begin
				case (src)
					3'd0: begin
						if (cnd) begin
							d.n_mem = 2'd2;
							d.base  = BASE_SP;
						end
					end
					3'd1: begin
						if (dst != 3'd5 && dst != 3'd7) begin
							d.n_mem = 2'd2;
							d.base  = BASE_SP;
						end
					end
					3'd2, 3'd4: d.n_imm = 2'd2;
					3'd3: begin
						case (dst)
							3'd0:       d.n_imm = 2'd2;
							3'd2, 3'd3: d.n_imm = 2'd1;
							3'd4: begin
								d.n_mem = 2'd2;
								d.base  = BASE_SP;
							end
							default: ;
						endcase
					end
					3'd5: if (dst[0]) d.n_imm = 2'd2;
					3'd6: d.n_imm = 2'd1;
					default: ;
				endcase
			end
		endcase
		return d;
	endfunction

	// ---------------------------------------------------------------- memory

	c8080_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr16[ADDR_BITS-1:0]),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	// decode of the opcode, straight from memory in the cycle it arrives
	assign op_now   = (state_q == ST_RDW && phase_q == PH_OP) ? ram_rdata : op_q;
	assign cond_now = cond_ok(op_now[5:3], fl_q);
	assign dec      = decode(op_now, cond_now);

	always_comb begin
		case (dec.base)
			BASE_HL:  base_addr = hl_q;
			BASE_RP:  base_addr = pair16(op_q[5:4], bc_q, de_q, hl_q, sp_q);
			BASE_IMM: base_addr = imm_q;
			default:  base_addr = sp_q;
		endcase
		case (phase_q)
			PH_OP, PH_IMM: rd_addr = pc_q;
			PH_MEM:        rd_addr = base_addr + {15'd0, cnt_q};
			default:       rd_addr = addr_q;
		endcase
	end

	// memory port select
	always_comb begin
		ram_we     = 1'b0;
		ram_wdata  = data;
		ram_addr16 = rd_addr;
		if (state_q == ST_IDLE) begin
			ram_addr16 = address;
			ram_we     = acc && (command == CMD_WRITE);
		end else if (state_q == ST_WR) begin
			ram_addr16 = wr_base_q + {15'd0, cnt_q};
			ram_we     = 1'b1;
			ram_wdata  = cnt_q ? wr_data_q[15:8] : wr_data_q[7:0];
		end
	end

	// ---------------------------------------------------------------- execute

	logic [2:0]  dst, src;
	logic [1:0]  rp;
	logic        use_alu;
	alu_res_t    alu_res;
	logic [7:0]  alu_b;
	logic [7:0]  ex_x, ex_v;
	logic [2:0]  ex_szp;
	logic [16:0] ex_sum;
	logic [15:0] ex_pair;
	logic        cond_q;

	assign dst     = op_q[5:3];
	assign src     = op_q[2:0];
	assign rp      = op_q[5:4];
	assign cond_q  = cond_ok(dst, fl_q);
	assign ex_x    = reg8(dst, bc_q, de_q, hl_q, mem_q[7:0], a_q);
	assign ex_pair = pair16(rp, bc_q, de_q, hl_q, sp_q);
	assign ex_sum  = {1'b0, ex_pair} + {1'b0, hl_q};
	assign ex_v    = (src == 3'd4) ? ex_x + 8'd1 : ex_x - 8'd1;
	assign ex_szp  = szp(ex_v);
	// register source for moves and register forms, immediate otherwise
	assign alu_b   = (op_q[7:6] == 2'd1 || op_q[7:6] == 2'd2) ?
		reg8(src, bc_q, de_q, hl_q, mem_q[7:0], a_q) : imm_q[7:0];

	c8080_alu u_alu (
		.op  (dst),
		.a   (a_q),
		.b   (alu_b),
		.cy  (fl_q[0]),
		.res (alu_res)
	);

	logic [15:0] nx_pc, nx_sp, nx_bc, nx_de, nx_hl;
	logic [7:0]  nx_a;
	logic [4:0]  nx_fl;
	logic        nx_halt;
	logic [1:0]  nx_wr_n;
	logic [15:0] nx_wr_base, nx_wr_data;
	logic        nx_pw, nx_bad;
	logic [7:0]  nx_pn, nx_pd;
	logic        reg_we, pair_we;
	logic [7:0]  reg_v;
	logic [15:0] pair_v;

	// next architectural state of one instruction
	always_comb begin
		nx_pc      = pc_q;
		nx_sp      = sp_q;
		nx_a       = a_q;
		nx_bc      = bc_q;
		nx_de      = de_q;
		nx_hl      = hl_q;
		nx_fl      = fl_q;
		nx_halt    = halt_q;
		nx_wr_n    = 2'd0;
		nx_wr_base = sp_q - 16'd2;
		nx_wr_data = pc_q;
		nx_pw      = 1'b0;
		nx_pn      = 8'd0;
		nx_pd      = 8'd0;
		nx_bad     = 1'b0;
		reg_we     = 1'b0;
		reg_v      = imm_q[7:0];
		pair_we    = 1'b0;
		pair_v     = imm_q;
		use_alu    = 1'b0;
		case (op_q[7:6])
			2'd1: begin
				if (op_q == OP_HLT) begin
					nx_halt = 1'b1;
				end else begin
					reg_we = 1'b1;
					reg_v  = alu_b;
				end
			end
			2'd2: use_alu = 1'b1;
			2'd0: begin
				case (src)
					3'd1: begin
						if (dst[0]) begin
							nx_fl[0] = ex_sum[16];
							nx_hl    = ex_sum[15:0];
						end else begin
							pair_we = 1'b1;
						end
					end
					3'd2: begin
						case (dst)
							3'd7: nx_a = mem_q[7:0];
							3'd6: begin
								nx_wr_n    = 2'd1;
								nx_wr_base = imm_q;
								nx_wr_data = {8'd0, a_q};
							end
							3'd5: nx_hl = mem_q;
							3'd4: begin
								nx_wr_n    = 2'd2;
								nx_wr_base = imm_q;
								nx_wr_data = hl_q;
							end
							default: begin
								if (dst[0]) begin
									nx_a = mem_q[7:0];
								end else begin
									nx_wr_n    = 2'd1;
									nx_wr_base = ex_pair;
									nx_wr_data = {8'd0, a_q};
								end
							end
						endcase
					end
					3'd3: begin
						pair_we = 1'b1;
						pair_v  = dst[0] ? ex_pair - 16'd1 : ex_pair + 16'd1;
					end
					3'd4, 3'd5: begin
						reg_we = 1'b1;
						reg_v  = ex_v;
						nx_fl  = {ex_szp[2], ex_szp[1],
							(src == 3'd4) ? (ex_v[3:0] == 4'd0) : (ex_x[3:0] != 4'd0),
							ex_szp[0], fl_q[0]};
					end
					3'd6: reg_we = 1'b1;
					3'd7: begin
						case (dst)
							3'd0: begin
								nx_a     = {a_q[6:0], a_q[7]};
								nx_fl[0] = a_q[7];
							end
							3'd1: begin
								nx_a     = {a_q[0], a_q[7:1]};
								nx_fl[0] = a_q[0];
							end
							3'd2: begin
								nx_a     = {a_q[6:0], fl_q[0]};
								nx_fl[0] = a_q[7];
							end
							3'd3: begin
								nx_a     = {fl_q[0], a_q[7:1]};
								nx_fl[0] = a_q[0];
							end
							3'd5: nx_a = ~a_q;
							3'd6: nx_fl[0] = 1'b1;
							3'd7: nx_fl[0] = ~fl_q[0];
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			default: begin
				case (src)
					3'd0: begin
						if (cond_q) begin
							nx_pc = mem_q;
							nx_sp = sp_q + 16'd2;
						end
					end
					3'd1: begin
						if (dst == 3'd1 || dst == 3'd3) begin
							nx_pc = mem_q;
							nx_sp = sp_q + 16'd2;
						end else if (dst == 3'd5) begin
							nx_pc = hl_q;
						end else if (dst == 3'd7) begin
							nx_sp = hl_q;
						end else if (rp == 2'd3) begin
							nx_a  = mem_q[15:8];
							nx_fl = {mem_q[7], mem_q[6], mem_q[4], mem_q[2], mem_q[0]};
							nx_sp = sp_q + 16'd2;
						end else begin
							pair_we = 1'b1;
							pair_v  = mem_q;
							nx_sp   = sp_q + 16'd2;
						end
					end
					3'd2: if (cond_q) nx_pc = imm_q;
					3'd3: begin
						case (dst)
							3'd0: nx_pc = imm_q;
							3'd1: nx_bad = (op_q == OP_BAD);
							3'd2: begin
								nx_pw = 1'b1;
								nx_pn = imm_q[7:0];
								nx_pd = a_q;
							end
							3'd3: begin
								nx_pn = imm_q[7:0];
								nx_a  = data_q;
							end
							3'd4: begin
								nx_hl      = mem_q;
								nx_wr_n    = 2'd2;
								nx_wr_base = sp_q;
								nx_wr_data = hl_q;
							end
							3'd5: begin
								nx_de = hl_q;
								nx_hl = de_q;
							end
							default: ;
						endcase
					end
					3'd4: begin
						if (cond_q) begin
							nx_wr_n = 2'd2;
							nx_sp   = sp_q - 16'd2;
							nx_pc   = imm_q;
						end
					end
					3'd5: begin
						nx_wr_n = 2'd2;
						nx_sp   = sp_q - 16'd2;
						if (dst[0]) begin
							nx_pc = imm_q;
						end else if (rp == 2'd3) begin
							nx_wr_data = {a_q, fl_q[4], fl_q[3], 1'b0, fl_q[2], 1'b0,
								fl_q[1], 1'b1, fl_q[0]};
						end else begin
							nx_wr_data = ex_pair;
						end
					end
					3'd6: use_alu = 1'b1;
					default: begin
						nx_wr_n = 2'd2;
						nx_sp   = sp_q - 16'd2;
						nx_pc   = {10'd0, dst, 3'd0};
					end
				endcase
			end
		endcase

		// single register write, memory operand goes through the write step
		if (reg_we) begin
			case (dst)
				3'd0: nx_bc[15:8] = reg_v;
				3'd1: nx_bc[7:0]  = reg_v;
				3'd2: nx_de[15:8] = reg_v;
				3'd3: nx_de[7:0]  = reg_v;
				3'd4: nx_hl[15:8] = reg_v;
				3'd5: nx_hl[7:0]  = reg_v;
				3'd6: begin
					nx_wr_n    = 2'd1;
					nx_wr_base = hl_q;
					nx_wr_data = {8'd0, reg_v};
				end
				default: nx_a = reg_v;
			endcase
		end

		// register pair write
		if (pair_we) begin
			case (rp)
				2'd0:    nx_bc = pair_v;
				2'd1:    nx_de = pair_v;
				2'd2:    nx_hl = pair_v;
				default: nx_sp = pair_v;
			endcase
		end

		// accumulator unit result
		if (use_alu) begin
			if (alu_res.wr_a) nx_a = alu_res.r;
			nx_fl = {alu_res.s, alu_res.z, alu_res.ac, alu_res.p, alu_res.c};
		end
	end

	// ---------------------------------------------------------------- sequencer

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_OP;
			cnt_q       <= 1'b0;
			pc_q        <= '0;
			sp_q        <= '0;
			a_q         <= '0;
			bc_q        <= '0;
			de_q        <= '0;
			hl_q        <= '0;
			fl_q        <= '0;
			halt_q      <= 1'b0;
			wr_n_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the done step reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cmd_q  <= command;
						addr_q <= address;
						data_q <= data;
						pw_q   <= 1'b0;
						pn_q   <= 8'd0;
						pd_q   <= 8'd0;
						rdat_q <= 8'd0;
						bad_q  <= 1'b0;
						cnt_q  <= 1'b0;
						if (command == CMD_READ) begin
							phase_q <= PH_CMD;
							state_q <= ST_RD;
						end else if (command == CMD_EXEC && !halt_q) begin
							phase_q <= PH_OP;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				// address goes to memory; fetches advance the pc
				ST_RD: begin
					if (phase_q == PH_OP || phase_q == PH_IMM) begin
						pc_q <= pc_q + 16'd1;
					end
					state_q <= ST_RDW;
				end
				// byte arrives; pick the next fetch, read or execute
				ST_RDW: begin
					case (phase_q)
						PH_CMD: begin
							rdat_q  <= ram_rdata;
							state_q <= ST_DONE;
						end
						PH_OP: begin
							op_q  <= ram_rdata;
							cnt_q <= 1'b0;
							if (dec.n_imm != 2'd0) begin
								phase_q <= PH_IMM;
								state_q <= ST_RD;
							end else if (dec.n_mem != 2'd0) begin
								phase_q <= PH_MEM;
								state_q <= ST_RD;
							end else begin
								state_q <= ST_EXEC;
							end
						end
						PH_IMM: begin
							if (cnt_q) imm_q[15:8] <= ram_rdata;
							else       imm_q[7:0]  <= ram_rdata;
							if (!cnt_q && dec.n_imm == 2'd2) begin
								cnt_q   <= 1'b1;
								state_q <= ST_RD;
							end else if (dec.n_mem != 2'd0) begin
								cnt_q   <= 1'b0;
								phase_q <= PH_MEM;
								state_q <= ST_RD;
							end else begin
								cnt_q   <= 1'b0;
								state_q <= ST_EXEC;
							end
						end
						default: begin
							if (cnt_q) mem_q[15:8] <= ram_rdata;
							else       mem_q[7:0]  <= ram_rdata;
							if (!cnt_q && dec.n_mem == 2'd2) begin
								cnt_q   <= 1'b1;
								state_q <= ST_RD;
							end else begin
								cnt_q   <= 1'b0;
								state_q <= ST_EXEC;
							end
						end
					endcase
				end
				ST_EXEC: begin
					pc_q      <= nx_pc;
					sp_q      <= nx_sp;
					a_q       <= nx_a;
					bc_q      <= nx_bc;
					de_q      <= nx_de;
					hl_q      <= nx_hl;
					fl_q      <= nx_fl;
					halt_q    <= nx_halt;
					wr_n_q    <= nx_wr_n;
					wr_base_q <= nx_wr_base;
					wr_data_q <= nx_wr_data;
					pw_q      <= nx_pw;
					pn_q      <= nx_pn;
					pd_q      <= nx_pd;
					bad_q     <= nx_bad;
					cnt_q     <= 1'b0;
					state_q   <= (nx_wr_n != 2'd0) ? ST_WR : ST_DONE;
				end
				ST_WR: begin
					if (!cnt_q && wr_n_q == 2'd2) begin
						cnt_q <= 1'b1;
					end else begin
						cnt_q   <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				default: begin
					// result word into the output register once it is free
					if (!out_valid_q || out_ready) begin
						o_pc_q      <= pc_q;
						o_sp_q      <= sp_q;
						o_a_q       <= a_q;
						o_fl_q      <= {fl_q[4], fl_q[3], 1'b0, fl_q[2], 1'b0,
							fl_q[1], 1'b1, fl_q[0]};
						o_halt_q    <= halt_q;
						o_pw_q      <= pw_q;
						o_pn_q      <= pn_q;
						o_pd_q      <= pd_q;
						o_rdat_q    <= rdat_q;
						o_bad_q     <= bad_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign program_counter  = o_pc_q;
	assign stack_pointer    = o_sp_q;
	assign accumulator      = o_a_q;
	assign status_flags     = o_fl_q;
	assign halted           = o_halt_q;
	assign port_write_valid = o_pw_q;
	assign port_number      = o_pn_q;
	assign port_data        = o_pd_q;
	assign read_data        = o_rdat_q;
	assign bad_opcode       = o_bad_q;

`ifndef SYNTHESIS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(halt_q))
		else $error("halt cleared without reset");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word loaded outside the done step");

	a_ram_write_scope: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_WR || (state_q == ST_IDLE && in_valid &&
			command == CMD_WRITE)))
		else $error("memory write outside a write command or write step");

	a_port_vs_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && o_pw_q) |-> (o_rdat_q == 8'd0 && !o_bad_q))
		else $error("port write word carries read data or bad opcode");

	a_exec_only_if_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> (cmd_q == CMD_EXEC && !halt_q))
		else $error("instruction executed while halted or for another command");
`endif

endmodule

@@ tb/cpu8080_instruction_step_tb.sv @@
// testbench for the 8080 instruction step core: directed and random command streams
`timescale 1ns / 1ps

module cpu8080_instruction_step_tb;
	import c8080_pkg::*;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_EXEC  = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// opcodes used by the directed part
	localparam logic [7:0] OP_HLT      = 8'h76;
	localparam logic [7:0] OP_LXI_SP   = 8'h31;
	localparam logic [7:0] OP_LXI_H    = 8'h21;
	localparam logic [7:0] OP_MVI_A    = 8'h3E;
	localparam logic [7:0] OP_MOV_A_M  = 8'h7E;
	localparam logic [7:0] OP_ADI      = 8'hC6;
	localparam logic [7:0] OP_SUI      = 8'hD6;
	localparam logic [7:0] OP_BAD      = 8'hCB;
	localparam logic [7:0] OP_ALT_NOP  = 8'h08;
	localparam logic [7:0] OP_DAA      = 8'h27;
	localparam logic [7:0] OP_DI       = 8'hF3;
	localparam logic [7:0] OP_EI       = 8'hFB;
	localparam logic [7:0] OP_OUT      = 8'hD3;
	localparam logic [7:0] OP_IN       = 8'hDB;
	localparam logic [7:0] OP_JMP      = 8'hC3;
	localparam logic [7:0] OP_CALL     = 8'hCD;
	localparam logic [7:0] OP_ALT_RET  = 8'hD9;
	localparam logic [7:0] OP_ALT_CALL = 8'hDD;
	localparam logic [7:0] OP_RET      = 8'hC9;
	localparam logic [7:0] OP_PUSH_PSW = 8'hF5;
	localparam logic [7:0] OP_POP_PSW  = 8'hF1;
	localparam logic [7:0] OP_XTHL     = 8'hE3;
	localparam logic [7:0] OP_SHLD     = 8'h22;
	localparam logic [7:0] OP_LHLD     = 8'h2A;

	localparam int IN_ITEMS = 800;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  data;
	} cmd_word_t;

	typedef struct packed {
		logic [15:0] program_counter;
		logic [15:0] stack_pointer;
		logic [7:0]  accumulator;
		logic [7:0]  status_flags;
		logic        halted;
		logic        port_write_valid;
		logic [7:0]  port_number;
		logic [7:0]  port_data;
		logic [7:0]  read_data;
		logic        bad_opcode;
	} step_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = CMD_WRITE;
	logic [15:0] address = '0;
	logic [7:0]  data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] program_counter, stack_pointer;
	logic [7:0]  accumulator, status_flags, port_number, port_data, read_data;
	logic        halted, port_write_valid, bad_opcode;

	cpu8080_instruction_step dut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// pending command words and the results they must produce
	cmd_word_t   pending_q[$];
	step_word_t  expected_q[$];
	logic [15:0] written_q[$];
	int          mismatches = 0;
	int          cycle_cnt = 0;
	logic        quiet;

	// core state as predicted
	logic [7:0]  mem_m [0:65535];
	bit          wr_mask [0:65535];
	logic [15:0] pc_m, sp_m, bc_m, de_m, hl_m;
	logic [7:0]  a_m;
	logic        fs, fz, fac, fp, fc, halt_m, ie_m;

	function automatic logic [7:0] rd8(input logic [15:0] a);
		return mem_m[a];
	endfunction

	function automatic void wr8(input logic [15:0] a, input logic [7:0] v);
		mem_m[a] = v;
		wr_mask[a] = 1'b1;
	endfunction

	function automatic logic [7:0] fetch8();
		logic [7:0] b;
		b = mem_m[pc_m];
		pc_m = pc_m + 16'd1;
		return b;
	endfunction

	function automatic logic [15:0] fetch16();
		logic [7:0] lo;
		lo = fetch8();
		return {fetch8(), lo};
	endfunction

	function automatic void set_szp(input logic [7:0] v);
		fs = v[7];
		fz = (v == 8'd0);
		fp = ~^v;
	endfunction

	function automatic logic [7:0] get_reg(input logic [2:0] id);
		case (id)
			3'd0: return bc_m[15:8];
			3'd1: return bc_m[7:0];
			3'd2: return de_m[15:8];
			3'd3: return de_m[7:0];
			3'd4: return hl_m[15:8];
			3'd5: return hl_m[7:0];
			3'd6: return rd8(hl_m);
			default: return a_m;
		endcase
	endfunction

	function automatic void set_reg(input logic [2:0] id, input logic [7:0] v);
		case (id)
			3'd0: bc_m[15:8] = v;
			3'd1: bc_m[7:0] = v;
			3'd2: de_m[15:8] = v;
			3'd3: de_m[7:0] = v;
			3'd4: hl_m[15:8] = v;
			3'd5: hl_m[7:0] = v;
			3'd6: wr8(hl_m, v);
			default: a_m = v;
		endcase
	endfunction

	function automatic logic [15:0] get_pair(input logic [1:0] id);
		case (id)
			2'd0: return bc_m;
			2'd1: return de_m;
			2'd2: return hl_m;
			default: return sp_m;
		endcase
	endfunction

	function automatic void set_pair(input logic [1:0] id, input logic [15:0] v);
		case (id)
			2'd0: bc_m = v;
			2'd1: de_m = v;
			2'd2: hl_m = v;
			default: sp_m = v;
		endcase
	endfunction

	function automatic void push16(input logic [15:0] v);
		wr8(sp_m - 16'd1, v[15:8]);
		wr8(sp_m - 16'd2, v[7:0]);
		sp_m = sp_m - 16'd2;
	endfunction

	function automatic logic [15:0] pop16();
		logic [15:0] w;
		w = {rd8(sp_m + 16'd1), rd8(sp_m)};
		sp_m = sp_m + 16'd2;
		return w;
	endfunction

	function automatic logic cond_true(input logic [2:0] id);
		logic f;
		case (id[2:1])
			2'd0: f = fz;
			2'd1: f = fc;
			2'd2: f = fp;
			default: f = fs;
		endcase
		return id[0] ? f : !f;
	endfunction

	function automatic logic [7:0] psw_byte();
		return {fs, fz, 1'b0, fac, 1'b0, fp, 1'b1, fc};
	endfunction

	// accumulator arithmetic and logic
	function automatic void alu_op(input logic [2:0] op, input logic [7:0] v);
		logic [9:0] r;
		logic [4:0] h;
		logic [7:0] nb;
		logic       cin;
		case (op)
			ALU_ADD, ALU_ADC: begin
				cin = (op == ALU_ADC) & fc;
				r = {2'b0, a_m} + {2'b0, v} + {9'd0, cin};
				h = {1'b0, a_m[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
				fac = h[4];
				fc = r[8];
				set_szp(r[7:0]);
				a_m = r[7:0];
			end
			ALU_SUB, ALU_SBB, ALU_CMP: begin
				cin = (op == ALU_SBB) ? ~fc : 1'b1;
				nb = ~v;
				r = {2'b0, a_m} + {2'b0, nb} + {9'd0, cin};
				h = {1'b0, a_m[3:0]} + {1'b0, nb[3:0]} + {4'd0, cin};
				fac = h[4];
				fc = ~r[8];
				set_szp(r[7:0]);
				if (op != ALU_CMP) a_m = r[7:0];
			end
			ALU_ANA: begin
				fac = a_m[3] | v[3];
				fc = 1'b0;
				a_m = a_m & v;
				set_szp(a_m);
			end
			default: begin
				fac = 1'b0;
				fc = 1'b0;
				a_m = (op == ALU_XRA) ? (a_m ^ v) : (a_m | v);
				set_szp(a_m);
			end
		endcase
	endfunction

	// one instruction
	function automatic void exec_instr(input logic [7:0] port_in, inout step_word_t r);
		logic [7:0]  op, v, acc;
		logic [2:0]  dst, src;
		logic [1:0]  rp;
		logic [15:0] w, t;
		logic [16:0] s;
		op = fetch8();
		dst = op[5:3];
		src = op[2:0];
		rp = op[5:4];
		case (op[7:6])
			2'd1: begin
				if (op == OP_HLT) halt_m = 1'b1;
				else set_reg(dst, get_reg(src));
			end
			2'd2: alu_op(dst, get_reg(src));
			2'd0: begin
				case (src)
					3'd1: begin
						if (dst[0]) begin
							s = {1'b0, get_pair(rp)} + {1'b0, hl_m};
							fc = s[16];
							hl_m = s[15:0];
						end else set_pair(rp, fetch16());
					end
					3'd2: begin
						case (dst)
							3'd7: a_m = rd8(fetch16());
							3'd6: wr8(fetch16(), a_m);
							3'd5: begin
								w = fetch16();
								hl_m = {rd8(w + 16'd1), rd8(w)};
							end
							3'd4: begin
								w = fetch16();
								wr8(w, hl_m[7:0]);
								wr8(w + 16'd1, hl_m[15:8]);
							end
							default: begin
								if (dst[0]) a_m = rd8(get_pair(rp));
								else wr8(get_pair(rp), a_m);
							end
						endcase
					end
					3'd3: set_pair(rp, dst[0] ? get_pair(rp) - 16'd1 : get_pair(rp) + 16'd1);
					3'd4: begin
						v = get_reg(dst) + 8'd1;
						fac = (v[3:0] == 4'd0);
						set_szp(v);
						set_reg(dst, v);
					end
					3'd5: begin
						v = get_reg(dst);
						fac = (v[3:0] != 4'd0);
						v = v - 8'd1;
						set_szp(v);
						set_reg(dst, v);
					end
					3'd6: set_reg(dst, fetch8());
					3'd7: begin
						acc = a_m;
						case (dst)
							3'd0: begin a_m = {acc[6:0], acc[7]}; fc = acc[7]; end
							3'd1: begin a_m = {acc[0], acc[7:1]}; fc = acc[0]; end
							3'd2: begin a_m = {acc[6:0], fc}; fc = acc[7]; end
							3'd3: begin a_m = {fc, acc[7:1]}; fc = acc[0]; end
							3'd5: a_m = ~acc;
							3'd6: fc = 1'b1;
							3'd7: fc = ~fc;
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			default: begin
				case (src)
					3'd0: if (cond_true(dst)) pc_m = pop16();
					3'd1: begin
						if (dst == 3'd1 || dst == 3'd3) pc_m = pop16();
						else if (dst == 3'd5) pc_m = hl_m;
						else if (dst == 3'd7) sp_m = hl_m;
						else if (rp == 2'd3) begin
							w = pop16();
							a_m = w[15:8];
							{fs, fz, fac, fp, fc} = {w[7], w[6], w[4], w[2], w[0]};
						end else set_pair(rp, pop16());
					end
					3'd2: begin
						w = fetch16();
						if (cond_true(dst)) pc_m = w;
					end
					3'd3: begin
						case (dst)
							3'd0: pc_m = fetch16();
							3'd1: r.bad_opcode = 1'b1;
							3'd2: begin
								r.port_number = fetch8();
								r.port_write_valid = 1'b1;
								r.port_data = a_m;
							end
							3'd3: begin
								r.port_number = fetch8();
								a_m = port_in;
							end
							3'd4: begin
								t = hl_m;
								hl_m = {rd8(sp_m + 16'd1), rd8(sp_m)};
								wr8(sp_m, t[7:0]);
								wr8(sp_m + 16'd1, t[15:8]);
							end
							3'd5: begin
								t = de_m;
								de_m = hl_m;
								hl_m = t;
							end
							3'd6: ie_m = 1'b0;
							default: ie_m = 1'b1;
						endcase
					end
					3'd4: begin
						w = fetch16();
						if (cond_true(dst)) begin
							push16(pc_m);
							pc_m = w;
						end
					end
					3'd5: begin
						if (dst[0]) begin
							w = fetch16();
							push16(pc_m);
							pc_m = w;
						end else if (rp == 2'd3) push16({a_m, psw_byte()});
						else push16(get_pair(rp));
					end
					3'd6: alu_op(dst, fetch8());
					default: begin
						push16(pc_m);
						pc_m = {10'd0, dst, 3'd0};
					end
				endcase
			end
		endcase
	endfunction

	// queue a command word together with the result it must produce
	function automatic void put_word(input logic [1:0] cmd, input logic [15:0] adr,
			input logic [7:0] dat);
		step_word_t r;
		cmd_word_t  c;
		r = '0;
		c.command = cmd;
		c.address = adr;
		c.data = dat;
		pending_q.push_back(c);
		case (cmd)
			CMD_WRITE: begin
				wr8(adr, dat);
				written_q.push_back(adr);
			end
			CMD_READ: r.read_data = rd8(adr);
			CMD_EXEC: if (!halt_m) exec_instr(dat, r);
			default: ;
		endcase
		r.program_counter = pc_m;
		r.stack_pointer = sp_m;
		r.accumulator = a_m;
		r.status_flags = psw_byte();
		r.halted = halt_m;
		expected_q.push_back(r);
	endfunction

	function automatic void fill_if_unwritten(input logic [15:0] a);
		if (!wr_mask[a]) put_word(CMD_WRITE, a, 8'($urandom));
	endfunction

	// lay down the instruction bytes at pc when fresh or unwritten, back every byte it reads, then execute
	function automatic void run_instr(input bit fresh, input logic [7:0] op,
			input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] port_in);
		logic [15:0] p1, p2, w;
		logic [7:0]  o;
		p1 = pc_m + 16'd1;
		p2 = pc_m + 16'd2;
		if (fresh || !wr_mask[pc_m] || !wr_mask[p1] || !wr_mask[p2] || mem_m[pc_m] == OP_HLT)
		begin
			put_word(CMD_WRITE, pc_m, op);
			put_word(CMD_WRITE, p1, b1);
			put_word(CMD_WRITE, p2, b2);
		end
		o = mem_m[pc_m];
		w = {mem_m[p2], mem_m[p1]};
		if ((o[7:6] == 2'd1 || o[7:6] == 2'd2) && o[2:0] == 3'd6) fill_if_unwritten(hl_m);
		if (o[7:6] == 2'd0) begin
			if ((o[2:0] == 3'd4 || o[2:0] == 3'd5) && o[5:3] == 3'd6) fill_if_unwritten(hl_m);
			if (o[2:0] == 3'd2) begin
				if (o[5:3] == 3'd7) fill_if_unwritten(w);
				if (o[5:3] == 3'd5) begin
					fill_if_unwritten(w);
					fill_if_unwritten(w + 16'd1);
				end
				if (o[5:3] == 3'd1 || o[5:3] == 3'd3) fill_if_unwritten(get_pair(o[5:4]));
			end
		end
		if (o[7:6] == 2'd3) begin
			fill_if_unwritten(sp_m);
			fill_if_unwritten(sp_m + 16'd1);
		end
		put_word(CMD_EXEC, 16'($urandom), port_in);
	endfunction

	function automatic void build_stimulus();
		int          pick;
		logic [7:0]  op;
		pc_m = '0; sp_m = '0; bc_m = '0; de_m = '0; hl_m = '0; a_m = '0;
		{fs, fz, fac, fp, fc} = '0;
		halt_m = 1'b0;
		ie_m = 1'b1;

		// address extremes, unused command, and the special opcodes
		put_word(CMD_WRITE, 16'h0000, 8'hFF);
		put_word(CMD_WRITE, 16'hFFFF, 8'h00);
		put_word(CMD_READ, 16'hFFFF, 8'h00);
		put_word(CMD_READ, 16'h0000, 8'hFF);
		put_word(CMD_SPARE, 16'hFFFF, 8'hFF);
		run_instr(1, OP_MVI_A, 8'hFF, 8'h00, 8'h00);
		run_instr(1, OP_ADI, 8'h01, 8'h00, 8'h00);
		run_instr(1, OP_SUI, 8'h01, 8'h00, 8'hFF);
		run_instr(1, OP_BAD, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_ALT_NOP, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_DAA, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_DI, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_EI, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_OUT, 8'hAA, 8'h00, 8'h00);
		run_instr(1, OP_IN, 8'h55, 8'h00, 8'h80);
		// pc and stack wrap around the top of memory
		run_instr(1, OP_JMP, 8'hFE, 8'hFF, 8'h00);
		run_instr(1, OP_CALL, 8'h00, 8'h10, 8'h00);
		run_instr(1, OP_ALT_RET, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_ALT_CALL, 8'h00, 8'h20, 8'h00);
		run_instr(1, OP_RET, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_PUSH_PSW, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_POP_PSW, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_LXI_H, 8'h34, 8'h12, 8'h00);
		run_instr(1, OP_XTHL, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_SHLD, 8'hFF, 8'hFF, 8'h00);
		run_instr(1, OP_LHLD, 8'hFF, 8'hFF, 8'h00);
		run_instr(1, OP_MOV_A_M, 8'h00, 8'h00, 8'h00);
		run_instr(1, OP_LXI_SP, 8'h00, 8'h00, 8'h00);

		// random programs with some memory traffic mixed in, up to the item budget
		while (pending_q.size() < IN_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 8) put_word(CMD_WRITE, 16'($urandom), 8'($urandom));
			else if (pick < 14)
				put_word(CMD_READ, written_q[$urandom_range(written_q.size() - 1)],
					8'($urandom));
			else if (pick < 16) put_word(CMD_SPARE, 16'($urandom), 8'($urandom));
			else begin
				do op = 8'($urandom); while (op == OP_HLT);
				run_instr(1'($urandom_range(1)), op, 8'($urandom), 8'($urandom),
					8'($urandom));
			end
		end

		// halt, then executes that must change nothing
		run_instr(1, OP_HLT, 8'h00, 8'h00, 8'h00);
		put_word(CMD_EXEC, 16'hFFFF, 8'hFF);
		put_word(CMD_EXEC, 16'h0000, 8'h00);
		put_word(CMD_READ, written_q[$urandom_range(written_q.size() - 1)], 8'h00);
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// cycle count and the window with no idling
	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;
	assign quiet = (cycle_cnt >= 3000 && cycle_cnt < 9000);

	// driver: present the next word once the current one is taken
	always @(posedge clk or negedge arst_n) begin : drive
		cmd_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_WRITE;
			address <= '0;
			data <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 12)) begin
				nxt = pending_q.pop_front();
				in_valid <= 1'b1;
				command <= nxt.command;
				address <= nxt.address;
				data <= nxt.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each taken result word, with one long hold-off
	always @(posedge clk or negedge arst_n) begin : watch
		step_word_t e;
		int         n_out;
		int         hold_cnt;
		bit         hold_done;
		if (!arst_n) begin
			out_ready <= 1'b0;
			n_out = 0;
			hold_cnt = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_out++;
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					e = expected_q.pop_front();
					check_field("program_counter", e.program_counter, program_counter);
					check_field("stack_pointer", e.stack_pointer, stack_pointer);
					check_field("accumulator", 16'(e.accumulator), 16'(accumulator));
					check_field("status_flags", 16'(e.status_flags), 16'(status_flags));
					check_field("halted", 16'(e.halted), 16'(halted));
					check_field("port_write_valid", 16'(e.port_write_valid),
						16'(port_write_valid));
					check_field("port_number", 16'(e.port_number), 16'(port_number));
					check_field("port_data", 16'(e.port_data), 16'(port_data));
					check_field("read_data", 16'(e.read_data), 16'(read_data));
					check_field("bad_opcode", 16'(e.bad_opcode), 16'(bad_opcode));
				end
			end
			if (!hold_done && n_out >= 150) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= 12;
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin : dog
		int stall;
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
			else stall++;
			if (stall >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
